/* rtl/stcag_pkg.sv */
// Shared widths, register indexes, state encoding and control structs of the strided copy engine.
package stcag_pkg;

  // Field widths
  localparam int ItemW   = 8;
  localparam int ExtW    = 16;
  localparam int StrideW = 32;
  localparam int OffW    = 32;
  localparam int IdxW    = 3;
  localparam int CfgW    = 32;

  // Widths of the running extent products
  localparam int P1W = ItemW + ExtW;
  localparam int P2W = P1W + ExtW;
  localparam int P3W = P2W + ExtW;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegItemBytes    = 3'd0;
  localparam logic [IdxW-1:0] RegExtentOuter  = 3'd1;
  localparam logic [IdxW-1:0] RegExtentMiddle = 3'd2;
  localparam logic [IdxW-1:0] RegExtentInner  = 3'd3;
  localparam logic [IdxW-1:0] RegStrideOuter  = 3'd4;
  localparam logic [IdxW-1:0] RegStrideMiddle = 3'd5;
  localparam logic [IdxW-1:0] RegStrideInner  = 3'd6;

  // Collapse level: number of dimensions walked by the counters
  typedef logic [1:0] level_t;
  localparam level_t LvlDense       = 2'd0;
  localparam level_t LvlWalkOuter   = 2'd1;
  localparam level_t LvlWalkMiddle  = 2'd2;
  localparam level_t LvlWalkInner   = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StProd1,
    StProd2,
    StProd3,
    StSetup,
    StEmit
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic prod1;
    logic prod2;
    logic prod3;
    logic setup;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic active;
  } status_t;

endpackage

/* rtl/strided_tensor_copy_address_gen_top.sv */
// Top level of the strided three-dimensional copy chunk generator.
//
// Usage: program the element size, three extents and three signed source
// strides on the configuration channel (cfg_valid_i/cfg_ready_o, register
// index and data); cfg_ready_o is always high and any write ends a running
// transfer. Each item on the request channel (in_valid_i/in_stall_o) with
// request_i set yields one chunk on the output channel (out_valid_o /
// out_stall_i): source offset, destination offset, byte length, last mark
// and size overflow flag. An item with request_i clear gives no chunk.
// The first request of a transfer runs a setup of three extent
// multiplies and the contiguity test before its chunk is loaded. Later
// requests give their chunk in the next cycle, one chunk per cycle while
// the output is not stalled.
// The output holds one item; while it is stalled, requests are stalled too.
// Reset sets the control, config and walk registers (sizes and strides 1)
// and no transfer is in progress; the next request starts one.
module strided_tensor_copy_address_gen_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stcag_pkg::IdxW-1:0]         cfg_index_i,
  input  logic [stcag_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               request_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [stcag_pkg::OffW-1:0]  src_offset_o,
  output logic [stcag_pkg::OffW-1:0]         dst_offset_o,
  output logic [stcag_pkg::OffW-1:0]         chunk_bytes_o,
  output logic                               last_chunk_o,
  output logic                               size_overflow_o
);

  stcag_pkg::cmd_t    cmd;
  stcag_pkg::status_t status;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  // Controller
  stcag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .request_i   (request_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  stcag_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .src_offset_o    (src_offset_o),
    .dst_offset_o    (dst_offset_o),
    .chunk_bytes_o   (chunk_bytes_o),
    .last_chunk_o    (last_chunk_o),
    .size_overflow_o (size_overflow_o)
  );

endmodule

/* rtl/stcag_ctrl.sv */
// Controller state machine: request handshake, transfer setup sequence and output valid.
module stcag_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                request_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  stcag_pkg::status_t  status_i,
  output stcag_pkg::cmd_t     cmd_o
);

  stcag_pkg::state_e state_q, state_d;
  logic              out_valid_q;
  logic              out_free;
  logic              idle_accept;

  // Output register can take a new item this cycle
  assign out_free    = !out_valid_q || !out_stall_i;
  assign idle_accept = in_valid_i && out_free && request_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stcag_pkg::StIdle: begin
        if (idle_accept && !status_i.active) begin
          state_d = stcag_pkg::StProd1;
        end
      end
      stcag_pkg::StProd1: state_d = stcag_pkg::StProd2;
      stcag_pkg::StProd2: state_d = stcag_pkg::StProd3;
      stcag_pkg::StProd3: state_d = stcag_pkg::StSetup;
      stcag_pkg::StSetup: state_d = stcag_pkg::StEmit;
      stcag_pkg::StEmit: begin
        if (out_free) begin
          state_d = stcag_pkg::StIdle;
        end
      end
      default: state_d = stcag_pkg::StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      stcag_pkg::StIdle: begin
        in_stall_o = !out_free;
        cmd_o.emit = idle_accept && status_i.active;
      end
      stcag_pkg::StProd1: cmd_o.prod1 = 1'b1;
      stcag_pkg::StProd2: cmd_o.prod2 = 1'b1;
      stcag_pkg::StProd3: cmd_o.prod3 = 1'b1;
      stcag_pkg::StSetup: cmd_o.setup = 1'b1;
      stcag_pkg::StEmit:  cmd_o.emit  = out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stcag_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // Setup only starts for a transfer that is not yet running
  a_setup_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stcag_pkg::StProd1 |-> !status_i.active)
    else $error("setup started while a transfer is active");

  // A transfer becomes active only out of the setup state
  a_active_from_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status_i.active) |-> $past(state_q) == stcag_pkg::StSetup)
    else $error("transfer activated outside setup");

  // Every emitted chunk shows up on the output
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted chunk not presented");
`endif

endmodule

/* rtl/stcag_datapath.sv */
// Datapath: configuration registers, extent product chain, odometer counters and output register.
module stcag_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [stcag_pkg::IdxW-1:0]         cfg_index_i,
  input  logic [stcag_pkg::CfgW-1:0]         cfg_data_i,
  input  stcag_pkg::cmd_t                    cmd_i,
  output stcag_pkg::status_t                 status_o,
  output logic signed [stcag_pkg::OffW-1:0]  src_offset_o,
  output logic [stcag_pkg::OffW-1:0]         dst_offset_o,
  output logic [stcag_pkg::OffW-1:0]         chunk_bytes_o,
  output logic                               last_chunk_o,
  output logic                               size_overflow_o
);

  localparam int ItemW   = stcag_pkg::ItemW;
  localparam int ExtW    = stcag_pkg::ExtW;
  localparam int StrideW = stcag_pkg::StrideW;
  localparam int OffW    = stcag_pkg::OffW;
  localparam int P1W     = stcag_pkg::P1W;
  localparam int P2W     = stcag_pkg::P2W;
  localparam int P3W     = stcag_pkg::P3W;

  // Configuration registers
  logic [ItemW-1:0]   item_q;
  logic [ExtW-1:0]    ext_o_q, ext_m_q, ext_i_q;
  logic [StrideW-1:0] stride_o_q, stride_m_q, stride_i_q;

  // Extent products (payload, no reset)
  logic [P1W-1:0] p1_q;
  logic [P2W-1:0] p2_q;
  logic [P3W-1:0] p3_q;

  // Walk state
  logic                 active_q;
  stcag_pkg::level_t    lvl_q;
  logic [ExtW-1:0]      cnt_o_q, cnt_m_q, cnt_i_q;
  logic [OffW-1:0]      acc_o_q, acc_m_q, acc_i_q;
  logic [OffW-1:0]      dst_q;
  logic [OffW-1:0]      len_q;
  logic                 big_q;

  // Output register
  logic [OffW-1:0] src_out_q, dst_out_q, bytes_out_q;
  logic            last_out_q, ovf_out_q;

  // Combinational helpers
  logic [ItemW-1:0]  item_eff;
  logic [ExtW-1:0]   eo_eff, em_eff, ei_eff;
  logic              inner_dense, middle_dense, outer_dense;
  stcag_pkg::level_t lvl_d;
  logic [OffW-1:0]   len_d;
  logic              big_d;
  logic              walk_o, walk_m, walk_i;
  logic [ExtW:0]     inc_o, inc_m, inc_i;
  logic              adv_o, adv_m, adv_i;
  logic              step_last;

  // A zero size or extent counts as one
  assign item_eff = (item_q == '0) ? ItemW'(1) : item_q;
  assign eo_eff   = (ext_o_q == '0) ? ExtW'(1) : ext_o_q;
  assign em_eff   = (ext_m_q == '0) ? ExtW'(1) : ext_m_q;
  assign ei_eff   = (ext_i_q == '0) ? ExtW'(1) : ext_i_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q     <= ItemW'(1);
      ext_o_q    <= ExtW'(1);
      ext_m_q    <= ExtW'(1);
      ext_i_q    <= ExtW'(1);
      stride_o_q <= StrideW'(1);
      stride_m_q <= StrideW'(1);
      stride_i_q <= StrideW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stcag_pkg::RegItemBytes:    item_q     <= cfg_data_i[ItemW-1:0];
        stcag_pkg::RegExtentOuter:  ext_o_q    <= cfg_data_i[ExtW-1:0];
        stcag_pkg::RegExtentMiddle: ext_m_q    <= cfg_data_i[ExtW-1:0];
        stcag_pkg::RegExtentInner:  ext_i_q    <= cfg_data_i[ExtW-1:0];
        stcag_pkg::RegStrideOuter:  stride_o_q <= cfg_data_i[StrideW-1:0];
        stcag_pkg::RegStrideMiddle: stride_m_q <= cfg_data_i[StrideW-1:0];
        stcag_pkg::RegStrideInner:  stride_i_q <= cfg_data_i[StrideW-1:0];
        default: ;
      endcase
    end
  end

  // Product chain, one multiply per setup step
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod1) begin
      p1_q <= P1W'(item_eff) * P1W'(ei_eff);
    end
    if (cmd_i.prod2) begin
      p2_q <= P2W'(p1_q) * P2W'(em_eff);
    end
    if (cmd_i.prod3) begin
      p3_q <= P3W'(p2_q) * P3W'(eo_eff);
    end
  end

  // Contiguity test: exact compare of the signed stride with the dense step
  assign inner_dense  = (stride_i_q == StrideW'(item_eff));
  assign middle_dense = (stride_m_q[StrideW-1:P1W] == '0) && (stride_m_q[P1W-1:0] == p1_q);
  assign outer_dense  = !stride_o_q[StrideW-1] && (p2_q[P2W-1:StrideW-1] == '0) &&
                        (p2_q[StrideW-2:0] == stride_o_q[StrideW-2:0]);

  // Collapse level and chunk length
  always_comb begin
    if (!inner_dense) begin
      lvl_d = stcag_pkg::LvlWalkInner;
    end else if (!middle_dense) begin
      lvl_d = stcag_pkg::LvlWalkMiddle;
    end else if (!outer_dense) begin
      lvl_d = stcag_pkg::LvlWalkOuter;
    end else begin
      lvl_d = stcag_pkg::LvlDense;
    end
    case (lvl_d)
      stcag_pkg::LvlWalkInner:  len_d = OffW'(item_eff);
      stcag_pkg::LvlWalkMiddle: len_d = OffW'(p1_q);
      stcag_pkg::LvlWalkOuter:  len_d = OffW'(p2_q);
      default:                  len_d = OffW'(p3_q);
    endcase
  end

  assign big_d = |p3_q[P3W-1:OffW];

  // Odometer step, innermost walked dimension fastest
  assign walk_i = (lvl_q == stcag_pkg::LvlWalkInner);
  assign walk_m = walk_i || (lvl_q == stcag_pkg::LvlWalkMiddle);
  assign walk_o = walk_m || (lvl_q == stcag_pkg::LvlWalkOuter);

  assign inc_i = {1'b0, cnt_i_q} + (ExtW+1)'(1);
  assign inc_m = {1'b0, cnt_m_q} + (ExtW+1)'(1);
  assign inc_o = {1'b0, cnt_o_q} + (ExtW+1)'(1);

  assign adv_i = walk_i && (inc_i < {1'b0, ei_eff});
  assign adv_m = !adv_i && walk_m && (inc_m < {1'b0, em_eff});
  assign adv_o = !adv_i && !adv_m && walk_o && (inc_o < {1'b0, eo_eff});
  assign step_last = !(adv_i || adv_m || adv_o);

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      lvl_q    <= stcag_pkg::LvlDense;
      cnt_o_q  <= '0;
      cnt_m_q  <= '0;
      cnt_i_q  <= '0;
      acc_o_q  <= '0;
      acc_m_q  <= '0;
      acc_i_q  <= '0;
      dst_q    <= '0;
      len_q    <= '0;
      big_q    <= 1'b0;
    end else if (cfg_valid_i || (cmd_i.emit && step_last)) begin
      // Any register write or the last chunk ends the transfer
      active_q <= 1'b0;
      lvl_q    <= stcag_pkg::LvlDense;
      cnt_o_q  <= '0;
      cnt_m_q  <= '0;
      cnt_i_q  <= '0;
      acc_o_q  <= '0;
      acc_m_q  <= '0;
      acc_i_q  <= '0;
      dst_q    <= '0;
      len_q    <= '0;
      big_q    <= 1'b0;
    end else if (cmd_i.setup) begin
      active_q <= 1'b1;
      lvl_q    <= lvl_d;
      len_q    <= len_d;
      big_q    <= big_d;
      cnt_o_q  <= '0;
      cnt_m_q  <= '0;
      cnt_i_q  <= '0;
      acc_o_q  <= '0;
      acc_m_q  <= '0;
      acc_i_q  <= '0;
      dst_q    <= '0;
    end else if (cmd_i.emit) begin
      dst_q <= dst_q + len_q;
      // Inner level
      if (adv_i) begin
        cnt_i_q <= inc_i[ExtW-1:0];
        acc_i_q <= acc_i_q + stride_i_q;
      end else begin
        cnt_i_q <= '0;
        acc_i_q <= '0;
      end
      // Middle level
      if (adv_m) begin
        cnt_m_q <= inc_m[ExtW-1:0];
        acc_m_q <= acc_m_q + stride_m_q;
      end else if (!adv_i) begin
        cnt_m_q <= '0;
        acc_m_q <= '0;
      end
      // Outer level
      if (adv_o) begin
        cnt_o_q <= inc_o[ExtW-1:0];
        acc_o_q <= acc_o_q + stride_o_q;
      end else if (!adv_i && !adv_m) begin
        cnt_o_q <= '0;
        acc_o_q <= '0;
      end
    end
  end

  // Output register, loaded with the current chunk
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      src_out_q   <= acc_o_q + acc_m_q + acc_i_q;
      dst_out_q   <= dst_q;
      bytes_out_q <= len_q;
      last_out_q  <= step_last;
      ovf_out_q   <= big_q;
    end
  end

  assign status_o.active = active_q;
  assign src_offset_o    = src_out_q;
  assign dst_offset_o    = dst_out_q;
  assign chunk_bytes_o   = bytes_out_q;
  assign last_chunk_o    = last_out_q;
  assign size_overflow_o = ovf_out_q;

`ifndef SYNTH
  // Setup arms the transfer
  a_setup_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.setup && !cfg_valid_i |=> active_q)
    else $error("setup did not start the transfer");

  // The last chunk closes the transfer
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && step_last |=> !active_q)
    else $error("transfer still active after last chunk");

  // Inner counter stays inside its extent
  a_inner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> cnt_i_q < ei_eff)
    else $error("inner counter out of range");
`endif

endmodule
